@@ rtl/cqp_pkg.sv @@
// Shared types and constants for the clique coverage pruner.
package cqp_pkg;

  localparam int VID_W       = 16;
  localparam int TR_W        = 8;
  localparam int THR_W       = 17;
  localparam int OUT_CNT_W   = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FRAC_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMES_REQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [TR_W-1:0]  TIMES_REQ_RST = TR_W'(1);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(49152);
  localparam logic [TR_W-1:0]  COV_MAX       = {TR_W{1'b1}};

  typedef struct packed {
    logic [VID_W-1:0] id;
    logic             last;
    logic             store;
    logic             in_rng;
  } cqp_item_t;

  typedef struct packed {
    logic [TR_W-1:0]  times_required;
    logic [THR_W-1:0] threshold;
  } cqp_cfg_t;

endpackage

@@ rtl/cqp_if.sv @@
// Channel interfaces: vertex input, result output and register writes.
interface cqp_in_if import cqp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VID_W-1:0] vertex_id;
  logic             last_vertex;
  modport source(output valid, vertex_id, last_vertex, input ready);
  modport sink(input valid, vertex_id, last_vertex, output ready);
endinterface

interface cqp_out_if import cqp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kept;
  logic [OUT_CNT_W-1:0] covered_vertices;
  logic [OUT_CNT_W-1:0] clique_size;
  modport source(output valid, kept, covered_vertices, clique_size, input ready);
  modport sink(input valid, kept, covered_vertices, clique_size, output ready);
endinterface

interface cqp_cfg_if import cqp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/cqp_queue.sv @@
// Short FIFO of classified vertices between front and back.
module cqp_queue import cqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cqp_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output cqp_item_t head_item
);

  cqp_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

endmodule

@@ rtl/cqp_front.sv @@
// Front end: takes vertices, tags capacity and id range, feeds the queue.
module cqp_front import cqp_pkg::*; #(
  parameter int NUM_VERTICES = 65536,
  parameter int MAX_CLIQUE   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [VID_W-1:0] in_vertex_id,
  input  logic       in_last_vertex,
  input  logic       clearing,
  input  logic       q_full,
  output logic       q_push,
  output cqp_item_t  q_item
);

  localparam int CW = $clog2(MAX_CLIQUE + 1);

  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic          store;

  assign in_ready = !clearing && !q_full;
  assign q_push   = in_valid && in_ready;
  assign store    = (fcnt_r < CW'(MAX_CLIQUE));

  always_comb begin
    q_item.id     = in_vertex_id;
    q_item.last   = in_last_vertex;
    q_item.store  = store;
    q_item.in_rng = (32'(in_vertex_id) < NUM_VERTICES);
  end

  always_comb begin
    fcnt_nxt = fcnt_r;
    if (q_push) begin
      if (in_last_vertex) fcnt_nxt = '0;
      else if (store) fcnt_nxt = fcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
    end
  end

endmodule

@@ rtl/cqp_back.sv @@
// Back end: table clear, coverage lookup, clique decision, write-back pass, result register.
module cqp_back import cqp_pkg::*; #(
  parameter int NUM_VERTICES = 65536,
  parameter int MAX_CLIQUE   = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cqp_cfg_t             cfg,
  input  logic                 q_not_empty,
  input  cqp_item_t            q_item,
  output logic                 q_pop,
  output logic                 clearing,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_kept,
  output logic [OUT_CNT_W-1:0] out_covered,
  output logic [OUT_CNT_W-1:0] out_size
);

  localparam int TBL_DEPTH = (NUM_VERTICES > 65536) ? 65536 : NUM_VERTICES;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int CW        = $clog2(MAX_CLIQUE + 1);
  localparam int BW        = $clog2(MAX_CLIQUE);
  localparam int PW        = THR_W + CW;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_RUN    = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_DEC    = 8'b0000_1000,
    S_WB_BUF = 8'b0001_0000,
    S_WB_TBL = 8'b0010_0000,
    S_WB_WR  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [TR_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [TR_W-1:0]  tbl_rd_r;
  logic             tbl_we;
  logic [AW-1:0]    tbl_addr;
  logic [TR_W-1:0]  tbl_wd;

  logic [VID_W-1:0] buf_mem [MAX_CLIQUE];
  logic [VID_W-1:0] buf_rd_r;
  logic             buf_we;

  logic [AW-1:0]    clr_r, clr_nxt;
  logic             s1_vld_r, s1_vld_nxt;
  cqp_item_t        s1_r;
  logic [CW-1:0]    size_r, size_nxt;
  logic [CW-1:0]    cov_r, cov_nxt;
  logic [BW-1:0]    wi_r, wi_nxt;
  logic [PW-1:0]    prod_r;
  logic             keep_r, keep_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             load_out;
  logic             hit;
  logic             wb_in_rng;
  logic [PW-1:0]    lhs;

  assign clearing  = (state_r == S_CLEAR);
  assign q_pop     = (state_r == S_RUN) && q_not_empty && !(s1_vld_r && s1_r.last);
  assign hit       = s1_r.in_rng && (tbl_rd_r > cfg.times_required);
  assign wb_in_rng = (32'(buf_rd_r) < NUM_VERTICES);
  assign lhs       = PW'({cov_r, {FRAC_W{1'b0}}});
  assign buf_we    = (state_r == S_RUN) && s1_vld_r && s1_r.store;
  assign load_out  = (state_r == S_OUT) && (!out_vld_r || out_ready);
  assign out_valid = out_vld_r;

  always_comb begin
    tbl_we   = 1'b0;
    tbl_addr = q_item.id[AW-1:0];
    tbl_wd   = tbl_rd_r + 1'b1;
    case (state_r)
      S_CLEAR: begin
        tbl_we   = 1'b1;
        tbl_addr = clr_r;
        tbl_wd   = '0;
      end
      S_WB_TBL: tbl_addr = buf_rd_r[AW-1:0];
      S_WB_WR: begin
        tbl_addr = buf_rd_r[AW-1:0];
        tbl_we   = wb_in_rng && (tbl_rd_r != COV_MAX);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    s1_vld_nxt  = q_pop;
    size_nxt    = size_r;
    cov_nxt     = cov_r;
    wi_nxt      = wi_r;
    keep_nxt    = keep_r;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(TBL_DEPTH - 1)) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (s1_vld_r) begin
          if (s1_r.store) begin
            size_nxt = size_r + 1'b1;
            if (hit) cov_nxt = cov_r + 1'b1;
          end
          if (s1_r.last) state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_DEC;
      S_DEC: begin
        keep_nxt = !(lhs >= prod_r);
        wi_nxt   = '0;
        if (!(lhs >= prod_r) && (size_r != '0)) state_nxt = S_WB_BUF;
        else state_nxt = S_OUT;
      end
      S_WB_BUF: state_nxt = S_WB_TBL;
      S_WB_TBL: state_nxt = S_WB_WR;
      S_WB_WR: begin
        wi_nxt = wi_r + 1'b1;
        if ((CW'(wi_r) + 1'b1) == size_r) state_nxt = S_OUT;
        else state_nxt = S_WB_BUF;
      end
      S_OUT: begin
        if (load_out) begin
          out_vld_nxt = 1'b1;
          size_nxt    = '0;
          cov_nxt     = '0;
          state_nxt   = S_RUN;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      s1_vld_r  <= 1'b0;
      size_r    <= '0;
      cov_r     <= '0;
      wi_r      <= '0;
      keep_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      s1_vld_r  <= s1_vld_nxt;
      size_r    <= size_nxt;
      cov_r     <= cov_nxt;
      wi_r      <= wi_nxt;
      keep_r    <= keep_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_r <= q_item;
    if (state_r == S_MUL) prod_r <= PW'(cfg.threshold) * PW'(size_r);
    if (load_out) begin
      out_kept    <= keep_r;
      out_covered <= OUT_CNT_W'(cov_r);
      out_size    <= OUT_CNT_W'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_addr] <= tbl_wd;
    else tbl_rd_r <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[size_r[BW-1:0]] <= s1_r.id;
    buf_rd_r <= buf_mem[wi_r];
  end

endmodule

@@ rtl/clique_coverage_pruner.sv @@
// Top level of the clique coverage pruner: channels, registers, front, queue, back.
//
//  channel  dir  transfer moves
//  in_ch    in   vertex_id, last_vertex
//  out_ch   out  kept, covered_vertices, clique_size (one per clique)
//  cfg_ch   in   index, data (0: times_required, 1: uniqueness_threshold_q16)
//
//  Each vertex reads the back end's coverage table port; the next is popped while
//  it is counted. The final vertex adds S_MUL and S_DEC; a kept clique then writes
//  back via S_WB_BUF, S_WB_TBL, S_WB_WR per vertex on that single port, and S_OUT
//  loads the result. After reset a clearing pass zeroes all min(NUM_VERTICES,
//  65536) table entries; in_ch.ready stays low meanwhile, cfg_ch is always ready.
//  A 4-entry queue and the output register let either side stall on its own.
module clique_coverage_pruner import cqp_pkg::*; #(
  parameter int NUM_VERTICES = 65536,
  parameter int MAX_CLIQUE   = 64
) (
  input  logic clk,
  input  logic rst_n,
  cqp_in_if.sink    in_ch,
  cqp_out_if.source out_ch,
  cqp_cfg_if.sink   cfg_ch
);

  cqp_cfg_t  cfg_r;
  logic      clearing;
  logic      q_full, q_not_empty, q_push, q_pop;
  cqp_item_t push_item, head_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.times_required <= TIMES_REQ_RST;
      cfg_r.threshold      <= THRESHOLD_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TIMES_REQ) cfg_r.times_required <= cfg_ch.data[TR_W-1:0];
      if (cfg_ch.index == REG_THRESHOLD) cfg_r.threshold <= cfg_ch.data;
    end
  end

  cqp_front #(.NUM_VERTICES(NUM_VERTICES), .MAX_CLIQUE(MAX_CLIQUE)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_vertex_id  (in_ch.vertex_id),
    .in_last_vertex(in_ch.last_vertex),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  cqp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_item(head_item)
  );

  cqp_back #(.NUM_VERTICES(NUM_VERTICES), .MAX_CLIQUE(MAX_CLIQUE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_not_empty(q_not_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_kept   (out_ch.kept),
    .out_covered(out_ch.covered_vertices),
    .out_size   (out_ch.clique_size)
  );

endmodule

@@ rtl/cqp_checker.sv @@
// Port-level assertions for the clique coverage pruner, bound to the top level.
module cqp_checker import cqp_pkg::*; #(
  parameter int MAX_CLIQUE = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last_vertex,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_kept,
  input logic [OUT_CNT_W-1:0] out_covered,
  input logic [OUT_CNT_W-1:0] out_size
);

  logic [3:0] pend_r;
  logic       in_last_xfer, out_xfer;

  assign in_last_xfer = in_valid && in_ready && in_last_vertex;
  assign out_xfer     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_last_xfer && !out_xfer) begin
      pend_r <= pend_r + 1'b1;
    end else if (!in_last_xfer && out_xfer) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kept)
      && $stable(out_covered) && $stable(out_size))
    else $error("result changed while stalled");

  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_result_has_clique: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a finished clique");

  a_covered_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (MAX_CLIQUE < 128) |-> out_covered <= out_size && out_size != '0)
    else $error("covered count exceeds clique size");

endmodule

bind clique_coverage_pruner cqp_checker #(.MAX_CLIQUE(MAX_CLIQUE)) u_cqp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last_vertex(in_ch.last_vertex),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kept      (out_ch.kept),
  .out_covered   (out_ch.covered_vertices),
  .out_size      (out_ch.clique_size)
);
